FILE: rtl/lfm_pkg.sv
package lfm_pkg;

  localparam int DUTY_W     = 14;
  localparam int SENS_W     = 5;
  localparam int LED_W      = 8;
  localparam int MODE_W     = 4;
  localparam int STEPS_W    = 16;
  localparam int PHASE_W    = STEPS_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = DUTY_W + 5;
  localparam int QUOT_W     = PROD_W - 2;
  localparam int RECIP_W    = 16;
  localparam int RECIP_SH   = 18;

  localparam int TICK_DIVIDE_DEF = 2;

  // floor(y / 5) == (y * RECIP5) >> 18 holds for every y below 2**18
  localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'(52429);

  localparam logic [DUTY_W-1:0]  BASE_DUTY_RST = DUTY_W'(8000);
  localparam logic [STEPS_W-1:0] HOLD_RST      = STEPS_W'(1001);
  localparam logic [STEPS_W-1:0] BACKOFF_RST   = STEPS_W'(49000);

  localparam logic [SENS_W-1:0] PAT_RUN    = 5'h04;
  localparam logic [SENS_W-1:0] PAT_LRIGHT = 5'h06;
  localparam logic [SENS_W-1:0] PAT_RIGHT  = 5'h07;
  localparam logic [SENS_W-1:0] PAT_DRIGHT = 5'h03;
  localparam logic [SENS_W-1:0] PAT_LLEFT  = 5'h0c;
  localparam logic [SENS_W-1:0] PAT_LEFT   = 5'h1c;
  localparam logic [SENS_W-1:0] PAT_DLEFT  = 5'h18;

  localparam logic [LED_W-1:0] LED_RST    = 8'hff;
  localparam logic [LED_W-1:0] LED_IDLE   = 8'he0;
  localparam logic [LED_W-1:0] LED_COURSE = 8'he1;
  localparam logic [LED_W-1:0] LED_HARD   = 8'he2;
  localparam logic [LED_W-1:0] LED_TURN   = 8'hf0;
  localparam logic [LED_W-1:0] LED_LIGHT  = 8'hf2;
  localparam logic [LED_W-1:0] LED_RUN    = 8'hf3;

  localparam logic [MODE_W-1:0] MC_STOP    = 4'd0;
  localparam logic [MODE_W-1:0] MC_RUN     = 4'd1;
  localparam logic [MODE_W-1:0] MC_LRIGHT  = 4'd2;
  localparam logic [MODE_W-1:0] MC_RIGHT   = 4'd3;
  localparam logic [MODE_W-1:0] MC_DRIGHT  = 4'd4;
  localparam logic [MODE_W-1:0] MC_LLEFT   = 4'd5;
  localparam logic [MODE_W-1:0] MC_LEFT    = 4'd6;
  localparam logic [MODE_W-1:0] MC_DLEFT   = 4'd7;
  localparam logic [MODE_W-1:0] MC_COURSE  = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RIGHT_BASE = 2'd0,
    CFG_LEFT_BASE  = 2'd1,
    CFG_HOLD       = 2'd2,
    CFG_BACKOFF    = 2'd3
  } lfm_cfg_idx_t;

  typedef enum logic [8:0] {
    MD_STOP   = 9'b000000001,
    MD_RUN    = 9'b000000010,
    MD_LRIGHT = 9'b000000100,
    MD_RIGHT  = 9'b000001000,
    MD_DRIGHT = 9'b000010000,
    MD_LLEFT  = 9'b000100000,
    MD_LEFT   = 9'b001000000,
    MD_DLEFT  = 9'b010000000,
    MD_COURSE = 9'b100000000
  } lfm_mode_t;

  typedef struct packed {
    logic [DUTY_W-1:0] rf;
    logic [DUTY_W-1:0] rr;
    logic [DUTY_W-1:0] lf;
    logic [DUTY_W-1:0] lr;
  } lfm_duty_t;

  // Wheel speeds scaled from the base registers, plus course-out timing
  typedef struct packed {
    logic [DUTY_W-1:0]  r_full;
    logic [DUTY_W-1:0]  r_95;
    logic [DUTY_W-1:0]  r_50;
    logic [DUTY_W-1:0]  r_40;
    logic [DUTY_W-1:0]  r_35;
    logic [DUTY_W-1:0]  l_full;
    logic [DUTY_W-1:0]  l_95;
    logic [DUTY_W-1:0]  l_50;
    logic [DUTY_W-1:0]  l_40;
    logic [DUTY_W-1:0]  l_35;
    logic [STEPS_W-1:0] hold;
    logic [PHASE_W-1:0] total;
  } lfm_drv_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode_code;
    logic              course_busy;
  } lfm_follow_st_t;

  // floor(base * k / 20): drop two bits, then divide by five by reciprocal
  function automatic logic [DUTY_W-1:0] scale20(input logic [DUTY_W-1:0] base,
                                                input logic [4:0] k);
    logic [PROD_W-1:0]          x;
    logic [QUOT_W-1:0]          y;
    logic [QUOT_W+RECIP_W-1:0]  p;
    x = PROD_W'(base) * PROD_W'(k);
    y = x[PROD_W-1:2];
    p = (QUOT_W+RECIP_W)'(y) * (QUOT_W+RECIP_W)'(RECIP5);
    return p[RECIP_SH +: DUTY_W];
  endfunction

  function automatic logic [MODE_W-1:0] mode_code(input lfm_mode_t m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MD_RUN:    c = MC_RUN;
      MD_LRIGHT: c = MC_LRIGHT;
      MD_RIGHT:  c = MC_RIGHT;
      MD_DRIGHT: c = MC_DRIGHT;
      MD_LLEFT:  c = MC_LLEFT;
      MD_LEFT:   c = MC_LEFT;
      MD_DLEFT:  c = MC_DLEFT;
      MD_COURSE: c = MC_COURSE;
      default:   c = MC_STOP;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/lfm_if.sv
interface lfm_in_if;
  import lfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [SENS_W-1:0] line_sensors;
  logic              button_level;
  logic              debounce_tick;

  modport source (output valid, output line_sensors, output button_level,
                  output debounce_tick, input ready);
  modport sink   (input valid, input line_sensors, input button_level,
                  input debounce_tick, output ready);
endinterface

interface lfm_out_if;
  import lfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] right_fwd_duty;
  logic [DUTY_W-1:0] right_rev_duty;
  logic [DUTY_W-1:0] left_fwd_duty;
  logic [DUTY_W-1:0] left_rev_duty;
  logic [LED_W-1:0]  led_code;
  logic              running;
  logic [MODE_W-1:0] mode_code;

  modport source (output valid, output right_fwd_duty, output right_rev_duty,
                  output left_fwd_duty, output left_rev_duty, output led_code,
                  output running, output mode_code, input ready);
  modport sink   (input valid, input right_fwd_duty, input right_rev_duty,
                  input left_fwd_duty, input left_rev_duty, input led_code,
                  input running, input mode_code, output ready);
endinterface

FILE: rtl/lfm_scale.sv
module lfm_scale (
  input  logic                          clk,
  input  logic [lfm_pkg::DUTY_W-1:0]    right_base,
  input  logic [lfm_pkg::DUTY_W-1:0]    left_base,
  input  logic [lfm_pkg::STEPS_W-1:0]   hold_steps,
  input  logic [lfm_pkg::STEPS_W-1:0]   backoff_steps,
  output lfm_pkg::lfm_drv_t             drv_r
);
  import lfm_pkg::*;

  lfm_drv_t drv_nxt;

  always_comb begin
    drv_nxt.r_full = right_base;
    drv_nxt.r_95   = scale20(right_base, 5'd19);
    drv_nxt.r_50   = right_base >> 1;
    drv_nxt.r_40   = scale20(right_base, 5'd8);
    drv_nxt.r_35   = scale20(right_base, 5'd7);
    drv_nxt.l_full = left_base;
    drv_nxt.l_95   = scale20(left_base, 5'd19);
    drv_nxt.l_50   = left_base >> 1;
    drv_nxt.l_40   = scale20(left_base, 5'd8);
    drv_nxt.l_35   = scale20(left_base, 5'd7);
    drv_nxt.hold   = hold_steps;
    drv_nxt.total  = PHASE_W'(hold_steps) + PHASE_W'(backoff_steps);
  end

  // The user must change settings only while idle (not enforced here), so the registered lag is never seen
  always_ff @(posedge clk) begin
    drv_r <= drv_nxt;
  end

endmodule

FILE: rtl/lfm_button.sv
module lfm_button #(
  parameter int TICK_DIVIDE = lfm_pkg::TICK_DIVIDE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic button_level,
  input  logic debounce_tick,
  output logic run_nxt,
  output logic run_r
);
  import lfm_pkg::*;

  localparam int TP_W = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;

  logic [TP_W-1:0] phase_r, phase_nxt;
  logic [2:0]      samp_r, samp_nxt;
  logic            stable_r, stable_nxt;
  logic            tick_last, sample, all_eq, rise;

  always_comb begin
    tick_last  = (phase_r == TP_W'(TICK_DIVIDE - 1));
    sample     = step && debounce_tick && tick_last;
    samp_nxt   = sample ? {samp_r[1:0], button_level} : samp_r;
    all_eq     = (samp_r[1] == samp_r[0]) && (samp_r[0] == button_level);
    stable_nxt = (sample && all_eq) ? button_level : stable_r;
    rise       = stable_nxt && !stable_r;
    run_nxt    = run_r ^ rise;
    phase_nxt  = phase_r;
    if (step && debounce_tick) begin
      phase_nxt = tick_last ? '0 : phase_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      samp_r   <= '0;
      stable_r <= 1'b0;
      run_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      samp_r   <= samp_nxt;
      stable_r <= stable_nxt;
      run_r    <= run_nxt;
    end
  end

endmodule

FILE: rtl/lfm_follow.sv
module lfm_follow (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         run_nxt,
  input  logic [lfm_pkg::SENS_W-1:0]   sens,
  input  lfm_pkg::lfm_drv_t            drv,
  output lfm_pkg::lfm_duty_t           duty_r,
  output logic [lfm_pkg::LED_W-1:0]    led_r,
  output lfm_pkg::lfm_follow_st_t      st
);
  import lfm_pkg::*;

  lfm_mode_t          mode_r, mode_nxt;
  lfm_duty_t          duty_nxt;
  logic [LED_W-1:0]   led_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt, phase_inc;

  assign phase_inc      = phase_r + 1'b1;
  assign st.mode_code   = mode_code(mode_r);
  assign st.course_busy = (phase_r != '0);

  always_comb begin
    mode_nxt  = mode_r;
    duty_nxt  = duty_r;
    led_nxt   = led_r;
    phase_nxt = phase_r;
    if (!run_nxt) begin
      // motors off, mode frozen
      duty_nxt = '0;
    end else begin
      unique case (mode_r)
        MD_RUN: begin
          if (sens == PAT_RUN) begin
            duty_nxt = '{drv.r_full, '0, drv.l_full, '0};
            led_nxt  = LED_RUN;
          end else if (sens == PAT_LRIGHT) begin
            mode_nxt = MD_LRIGHT;
          end else if (sens == PAT_LLEFT) begin
            mode_nxt = MD_LLEFT;
          end
        end
        MD_LRIGHT: begin
          if (sens == PAT_LRIGHT) begin
            duty_nxt = '{drv.r_35, '0, drv.l_95, '0};
            led_nxt  = LED_LIGHT;
          end else if (sens == PAT_RIGHT) begin
            mode_nxt = MD_RIGHT;
          end else if (sens == PAT_RUN) begin
            mode_nxt = MD_RUN;
          end
        end
        MD_RIGHT: begin
          if (sens == PAT_RIGHT) begin
            duty_nxt = '{'0, '0, drv.l_50, '0};
            led_nxt  = LED_TURN;
          end else if (sens == PAT_LRIGHT) begin
            mode_nxt = MD_LRIGHT;
          end else if (sens == PAT_DRIGHT) begin
            mode_nxt = MD_DRIGHT;
          end else begin
            mode_nxt  = MD_COURSE;
            phase_nxt = '0;
          end
        end
        MD_DRIGHT: begin
          if (sens == PAT_DRIGHT) begin
            // inner wheel forward duty stays as it was
            duty_nxt.lr = '0;
            duty_nxt.rr = drv.r_40;
            duty_nxt.lf = drv.l_40;
            led_nxt     = LED_HARD;
          end else if (sens == PAT_RIGHT) begin
            mode_nxt = MD_RIGHT;
          end else begin
            mode_nxt  = MD_COURSE;
            phase_nxt = '0;
          end
        end
        MD_LLEFT: begin
          if (sens == PAT_LLEFT) begin
            duty_nxt = '{drv.r_95, '0, drv.l_35, '0};
            led_nxt  = LED_LIGHT;
          end else if (sens == PAT_LEFT) begin
            mode_nxt = MD_LEFT;
          end else if (sens == PAT_RUN) begin
            mode_nxt = MD_RUN;
          end
        end
        MD_LEFT: begin
          if (sens == PAT_LEFT) begin
            duty_nxt = '{drv.r_50, '0, '0, '0};
            led_nxt  = LED_TURN;
          end else if (sens == PAT_LLEFT) begin
            mode_nxt = MD_LLEFT;
          end else if (sens == PAT_DLEFT) begin
            mode_nxt = MD_DLEFT;
          end else begin
            mode_nxt  = MD_COURSE;
            phase_nxt = '0;
          end
        end
        MD_DLEFT: begin
          if (sens == PAT_DLEFT) begin
            duty_nxt.rr = '0;
            duty_nxt.rf = drv.r_40;
            duty_nxt.lr = drv.l_40;
            led_nxt     = LED_HARD;
          end else if (sens == PAT_LEFT) begin
            mode_nxt = MD_LEFT;
          end else begin
            mode_nxt  = MD_COURSE;
            phase_nxt = '0;
          end
        end
        MD_COURSE: begin
          led_nxt = LED_COURSE;
          // hold first, then back off at half speed
          if (phase_r >= PHASE_W'(drv.hold) && phase_r < drv.total) begin
            duty_nxt = '{'0, drv.r_50, '0, drv.l_50};
          end
          phase_nxt = phase_inc;
          if (phase_inc >= drv.total) begin
            mode_nxt  = MD_STOP;
            phase_nxt = '0;
          end
        end
        default: begin
          // stopped: wait for the center pattern
          if (sens == PAT_RUN) begin
            mode_nxt = MD_RUN;
          end else begin
            mode_nxt  = MD_STOP;
            led_nxt   = LED_IDLE;
            duty_nxt  = '0;
            phase_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MD_STOP;
      phase_r <= '0;
      duty_r  <= '{DUTY_W'(1), DUTY_W'(1), DUTY_W'(1), DUTY_W'(1)};
      led_r   <= LED_RST;
    end else if (step) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      duty_r  <= duty_nxt;
      led_r   <= led_nxt;
    end
  end

endmodule

FILE: rtl/line_follower_motor_fsm.sv
// Throughput: one word per cycle while the output is not stalled; the control
// step is a single registered pass from the input register through the mode FSM
// into the state/result registers.
// Reset (synchronous, rst_n low): mode stop, duties 1, LED 0xff, motors off,
// settings back to defaults; input is not taken while reset is held.
module line_follower_motor_fsm #(
  parameter int TICK_DIVIDE = lfm_pkg::TICK_DIVIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lfm_in_if.sink                          in_if,
  lfm_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [lfm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lfm_pkg::*;

  logic [DUTY_W-1:0]  right_base_r, left_base_r;
  logic [STEPS_W-1:0] hold_r, backoff_r;

  logic              in_vld_r, out_vld_r, advance;
  logic [SENS_W-1:0] sens_r;
  logic              level_r, tick_r;
  logic              run_nxt, run_r;

  lfm_drv_t       drv;
  lfm_duty_t      duty;
  logic [LED_W-1:0] led;
  lfm_follow_st_t st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_base_r <= BASE_DUTY_RST;
      left_base_r  <= BASE_DUTY_RST;
      hold_r       <= HOLD_RST;
      backoff_r    <= BACKOFF_RST;
    end else if (cfg_we) begin
      unique case (lfm_cfg_idx_t'(cfg_idx))
        CFG_RIGHT_BASE: right_base_r <= cfg_data[DUTY_W-1:0];
        CFG_LEFT_BASE:  left_base_r  <= cfg_data[DUTY_W-1:0];
        CFG_HOLD:       hold_r       <= cfg_data[STEPS_W-1:0];
        CFG_BACKOFF:    backoff_r    <= cfg_data[STEPS_W-1:0];
        default:        ;
      endcase
    end
  end

  // advance the held word when the result slot is free or being drained
  assign advance     = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = rst_n && (!in_vld_r || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      sens_r  <= in_if.line_sensors;
      level_r <= in_if.button_level;
      tick_r  <= in_if.debounce_tick;
    end
  end

  lfm_scale u_scale (
    .clk           (clk),
    .right_base    (right_base_r),
    .left_base     (left_base_r),
    .hold_steps    (hold_r),
    .backoff_steps (backoff_r),
    .drv_r         (drv)
  );

  lfm_button #(
    .TICK_DIVIDE (TICK_DIVIDE)
  ) u_button (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .button_level  (level_r),
    .debounce_tick (tick_r),
    .run_nxt       (run_nxt),
    .run_r         (run_r)
  );

  lfm_follow u_follow (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .run_nxt (run_nxt),
    .sens    (sens_r),
    .drv     (drv),
    .duty_r  (duty),
    .led_r   (led),
    .st      (st)
  );

  // the state registers double as the result register
  assign out_if.valid          = out_vld_r;
  assign out_if.right_fwd_duty = duty.rf;
  assign out_if.right_rev_duty = duty.rr;
  assign out_if.left_fwd_duty  = duty.lf;
  assign out_if.left_rev_duty  = duty.lr;
  assign out_if.led_code       = led;
  assign out_if.running        = run_r;
  assign out_if.mode_code      = st.mode_code;

  a_off_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !run_r) |-> (duty == '0))
    else $error("duty nonzero while motors disabled");

  a_phase_course: assert property (@(posedge clk) disable iff (!rst_n)
    st.course_busy |-> (st.mode_code == MC_COURSE))
    else $error("course-out phase counting outside course-out");

  a_run_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(run_r))
    else $error("run enable changed without a step");

endmodule

FILE: tb/line_follower_motor_fsm_tb.sv
`timescale 1ns / 1ps

module line_follower_motor_fsm_tb;
  import lfm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_AT     = 300;
  localparam int LONG_STALL  = 400;
  localparam int PHASES      = 8;

  // Duty fractions in twentieths of the base value
  localparam int unsigned K_FULL = 20;
  localparam int unsigned K_95   = 19;
  localparam int unsigned K_HALF = 10;
  localparam int unsigned K_40   = 8;
  localparam int unsigned K_35   = 7;

  typedef struct packed {
    logic [SENS_W-1:0] sens;
    logic              lvl;
    logic              tick;
  } step_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] rf;
    logic [DUTY_W-1:0] rr;
    logic [DUTY_W-1:0] lf;
    logic [DUTY_W-1:0] lr;
    logic [LED_W-1:0]  led;
    logic              run;
    logic [MODE_W-1:0] mode;
  } motor_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lfm_in_if  in_ch();
  lfm_out_if out_ch();

  line_follower_motor_fsm DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Controller copy: settings
  logic [DUTY_W-1:0]  base_r, base_l;
  logic [STEPS_W-1:0] hold_n, back_n;
  // Controller copy: state
  logic               mot_on;
  logic [MODE_W-1:0]  mode_q;
  lfm_duty_t          duty;
  logic [LED_W-1:0]   led_q;
  logic [PHASE_W-1:0] phase_q;
  logic               samp [3];
  logic               stable_q, prev_stable_q;
  int                 tick_ph;

  step_word_t  step_q[$];
  motor_word_t want_q[$];
  step_word_t  nxt;
  motor_word_t got_w;

  int  queued, mismatches, words_checked, toggles, courseouts, cycles;
  int  send_gap, stall_left, taken;
  bit  calm, long_done;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [DUTY_W-1:0] scaled(logic [DUTY_W-1:0] base, int unsigned k);
    int unsigned p;
    p = (base * k) / 20;
    return p[DUTY_W-1:0];
  endfunction

  function automatic lfm_duty_t pack_duty(logic [DUTY_W-1:0] rf, logic [DUTY_W-1:0] rr,
                                          logic [DUTY_W-1:0] lf, logic [DUTY_W-1:0] lr);
    lfm_duty_t d;
    d.rf = rf;
    d.rr = rr;
    d.lf = lf;
    d.lr = lr;
    return d;
  endfunction

  function automatic void reset_model();
    base_r = BASE_DUTY_RST;
    base_l = BASE_DUTY_RST;
    hold_n = HOLD_RST;
    back_n = BACKOFF_RST;
    mot_on = 1'b0;
    mode_q = MC_STOP;
    duty = pack_duty(DUTY_W'(1), DUTY_W'(1), DUTY_W'(1), DUTY_W'(1));
    led_q = LED_RST;
    phase_q = '0;
    samp[0] = 1'b0;
    samp[1] = 1'b0;
    samp[2] = 1'b0;
    stable_q = 1'b0;
    prev_stable_q = 1'b0;
    tick_ph = 0;
  endfunction

  function automatic void go_course();
    mode_q = MC_COURSE;
    phase_q = '0;
    courseouts++;
  endfunction

  function automatic void follow_line(logic [SENS_W-1:0] s);
    int unsigned total;
    case (mode_q)
      MC_RUN: begin
        if (s == PAT_RUN) begin
          duty = pack_duty(scaled(base_r, K_FULL), '0, scaled(base_l, K_FULL), '0);
          led_q = LED_RUN;
        end else if (s == PAT_LRIGHT) mode_q = MC_LRIGHT;
        else if (s == PAT_LLEFT) mode_q = MC_LLEFT;
      end
      MC_LRIGHT: begin
        if (s == PAT_LRIGHT) begin
          duty = pack_duty(scaled(base_r, K_35), '0, scaled(base_l, K_95), '0);
          led_q = LED_LIGHT;
        end else if (s == PAT_RIGHT) mode_q = MC_RIGHT;
        else if (s == PAT_RUN) mode_q = MC_RUN;
      end
      MC_RIGHT: begin
        if (s == PAT_RIGHT) begin
          duty = pack_duty('0, '0, scaled(base_l, K_HALF), '0);
          led_q = LED_TURN;
        end else if (s == PAT_LRIGHT) mode_q = MC_LRIGHT;
        else if (s == PAT_DRIGHT) mode_q = MC_DRIGHT;
        else go_course();
      end
      MC_DRIGHT: begin
        // inner wheel forward duty stays as it was
        if (s == PAT_DRIGHT) begin
          duty.lr = '0;
          duty.rr = scaled(base_r, K_40);
          duty.lf = scaled(base_l, K_40);
          led_q = LED_HARD;
        end else if (s == PAT_RIGHT) mode_q = MC_RIGHT;
        else go_course();
      end
      MC_LLEFT: begin
        if (s == PAT_LLEFT) begin
          duty = pack_duty(scaled(base_r, K_95), '0, scaled(base_l, K_35), '0);
          led_q = LED_LIGHT;
        end else if (s == PAT_LEFT) mode_q = MC_LEFT;
        else if (s == PAT_RUN) mode_q = MC_RUN;
      end
      MC_LEFT: begin
        if (s == PAT_LEFT) begin
          duty = pack_duty(scaled(base_r, K_HALF), '0, '0, '0);
          led_q = LED_TURN;
        end else if (s == PAT_LLEFT) mode_q = MC_LLEFT;
        else if (s == PAT_DLEFT) mode_q = MC_DLEFT;
        else go_course();
      end
      MC_DLEFT: begin
        if (s == PAT_DLEFT) begin
          duty.rr = '0;
          duty.rf = scaled(base_r, K_40);
          duty.lr = scaled(base_l, K_40);
          led_q = LED_HARD;
        end else if (s == PAT_LEFT) mode_q = MC_LEFT;
        else go_course();
      end
      MC_COURSE: begin
        total = int'(hold_n) + int'(back_n);
        led_q = LED_COURSE;
        // hold for the first hold_n steps, then back off at half speed
        if (phase_q >= PHASE_W'(hold_n) && phase_q < PHASE_W'(total))
          duty = pack_duty('0, scaled(base_r, K_HALF), '0, scaled(base_l, K_HALF));
        phase_q = phase_q + 1'b1;
        if (phase_q >= PHASE_W'(total)) begin
          mode_q = MC_STOP;
          phase_q = '0;
        end
      end
      default: begin
        mode_q = MC_STOP;
        if (s == PAT_RUN) begin
          mode_q = MC_RUN;
        end else begin
          led_q = LED_IDLE;
          duty = pack_duty('0, '0, '0, '0);
          phase_q = '0;
        end
      end
    endcase
  endfunction

  function automatic motor_word_t step_motor(logic [SENS_W-1:0] s, logic lvl, logic tick);
    motor_word_t w;
    logic rise;
    rise = 1'b0;
    if (tick) begin
      if (tick_ph + 1 >= TICK_DIVIDE_DEF) begin
        tick_ph = 0;
        samp[2] = samp[1];
        samp[1] = samp[0];
        samp[0] = lvl;
        if (samp[2] == samp[1] && samp[1] == samp[0]) stable_q = samp[0];
        if (stable_q != prev_stable_q) begin
          rise = stable_q;
          prev_stable_q = stable_q;
        end
      end else begin
        tick_ph++;
      end
    end
    if (rise) begin
      mot_on = !mot_on;
      toggles++;
    end
    if (mot_on) follow_line(s);
    else duty = pack_duty('0, '0, '0, '0);
    w.rf = duty.rf;
    w.rr = duty.rr;
    w.lf = duty.lf;
    w.lr = duty.lr;
    w.led = led_q;
    w.run = mot_on;
    w.mode = mode_q;
    return w;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: offer queued words, with occasional idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (step_q.size() > 0) begin
        nxt = step_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.line_sensors <= nxt.sens;
        in_ch.button_level <= nxt.lvl;
        in_ch.debounce_tick <= nxt.tick;
        if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 12);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      taken = 0;
      long_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) taken++;
      if (!long_done && taken == LONG_AT) begin
        stall_left = LONG_STALL;
        long_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: check the result word first, then predict the newly accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        words_checked++;
        if (want_q.size() == 0) begin
          $error("result word arrived with nothing expected");
          mismatches++;
        end else begin
          got_w = want_q.pop_front();
          check_field("right_fwd_duty", 16'(got_w.rf), 16'(out_ch.right_fwd_duty));
          check_field("right_rev_duty", 16'(got_w.rr), 16'(out_ch.right_rev_duty));
          check_field("left_fwd_duty", 16'(got_w.lf), 16'(out_ch.left_fwd_duty));
          check_field("left_rev_duty", 16'(got_w.lr), 16'(out_ch.left_rev_duty));
          check_field("led_code", 16'(got_w.led), 16'(out_ch.led_code));
          check_field("running", 16'(got_w.run), 16'(out_ch.running));
          check_field("mode_code", 16'(got_w.mode), 16'(out_ch.mode_code));
        end
      end
      if (in_ch.valid && in_ch.ready)
        want_q.push_back(step_motor(in_ch.line_sensors, in_ch.button_level,
                                    in_ch.debounce_tick));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_step(logic [SENS_W-1:0] s, logic lvl, logic tick);
    step_word_t w;
    w.sens = s;
    w.lvl = lvl;
    w.tick = tick;
    step_q.push_back(w);
    queued++;
  endtask

  task automatic add_track(logic [SENS_W-1:0] s);
    add_step(s, 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // Three agreeing samples need six ticks at the default divide
  task automatic add_press();
    repeat (6) add_step(5'($urandom_range(0, 31)), 1'b1, 1'b1);
  endtask

  task automatic add_lost();
    int n;
    n = int'(hold_n) + int'(back_n);
    if (n > 24) n = 24;
    n += $urandom_range(1, 3);
    add_track(5'h00);
    for (int i = 1; i < n; i++) begin
      if (i == n / 2 && $urandom_range(0, 3) == 0) add_press();
      add_track(5'($urandom_range(0, 31)));
    end
  endtask

  task automatic add_curve(bit right);
    logic [SENS_W-1:0] path [4];
    int depth;
    path[0] = PAT_RUN;
    path[1] = right ? PAT_LRIGHT : PAT_LLEFT;
    path[2] = right ? PAT_RIGHT : PAT_LEFT;
    path[3] = right ? PAT_DRIGHT : PAT_DLEFT;
    depth = $urandom_range(1, 3);
    for (int i = 0; i <= depth; i++) repeat ($urandom_range(1, 3)) add_track(path[i]);
    if (depth >= 2 && $urandom_range(0, 1) == 1) begin
      add_lost();
    end else begin
      for (int i = depth - 1; i >= 0; i--) repeat ($urandom_range(1, 2)) add_track(path[i]);
    end
  endtask

  task automatic fill_random(int target);
    int start;
    int r;
    start = queued;
    while (queued - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 6) add_press();
      else if (r < 16) begin
        repeat ($urandom_range(1, 4))
          add_step(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end else if (r < 28) repeat ($urandom_range(1, 4)) add_track(PAT_RUN);
      else add_curve(r < 64);
    end
  endtask

  task automatic set_reg(lfm_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_RIGHT_BASE: base_r = val[DUTY_W-1:0];
      CFG_LEFT_BASE:  base_l = val[DUTY_W-1:0];
      CFG_HOLD:       hold_n = val;
      CFG_BACKOFF:    back_n = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [15:0] r, logic [15:0] l, logic [15:0] h, logic [15:0] b);
    set_reg(CFG_RIGHT_BASE, r);
    set_reg(CFG_LEFT_BASE, l);
    set_reg(CFG_HOLD, h);
    set_reg(CFG_BACKOFF, b);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every offered word is taken and every expected word has come back
  task automatic drain();
    do @(negedge clk);
    while (step_q.size() != 0 || in_ch.valid || want_q.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.line_sensors = '0;
    in_ch.button_level = 1'b0;
    in_ch.debounce_tick = 1'b0;
    out_ch.ready = 1'b0;
    calm = 1'b0;
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: disabled word, start press, both curves down to course-out
    program_regs(16'd9999, 16'hffff, 16'd1, 16'd2);
    add_step(5'h1f, 1'b0, 1'b0);
    repeat (6) add_step(5'h1f, 1'b1, 1'b1);
    add_step(PAT_RUN, 1'b0, 1'b1);
    add_step(PAT_RUN, 1'b0, 1'b1);
    add_step(PAT_LRIGHT, 1'b0, 1'b1);
    add_step(PAT_LRIGHT, 1'b0, 1'b1);
    add_step(PAT_RIGHT, 1'b0, 1'b1);
    add_step(PAT_RIGHT, 1'b0, 1'b1);
    add_step(PAT_DRIGHT, 1'b0, 1'b1);
    add_step(PAT_DRIGHT, 1'b0, 1'b1);
    add_step(5'h00, 1'b0, 1'b1);
    repeat (3) add_step(5'h1f, 1'b0, 1'b0);
    add_step(PAT_RUN, 1'b0, 1'b0);
    add_step(PAT_LLEFT, 1'b0, 1'b1);
    add_step(PAT_LLEFT, 1'b0, 1'b0);
    add_step(PAT_LEFT, 1'b0, 1'b1);
    add_step(PAT_LEFT, 1'b0, 1'b0);
    add_step(PAT_DLEFT, 1'b0, 1'b1);
    add_step(PAT_DLEFT, 1'b0, 1'b0);
    add_step(5'h10, 1'b0, 1'b1);
    drain();

    for (int ph = 1; ph < PHASES; ph++) begin
      case (ph)
        1: program_regs(16'd8000, 16'd8000, 16'd3, 16'd5);
        2: program_regs(16'd0, 16'd0, 16'd0, 16'd0);
        3: program_regs(16'hffff, 16'd9999, 16'd0, 16'd4);
        4: program_regs(16'($urandom_range(0, 16383)), 16'($urandom_range(0, 16383)),
                        16'd6, 16'd0);
        5: program_regs(16'd1, 16'($urandom), 16'hffff, 16'hffff);
        6: program_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 8)),
                        16'($urandom_range(0, 12)));
        default: begin
          calm = 1'b1;
          program_regs(16'd9999, 16'd8000, 16'd2, 16'd3);
        end
      endcase
      // a very long course-out holds here, so keep this setting short
      fill_random(ph == 5 ? 120 : 280);
      drain();
    end
    repeat (4) @(posedge clk);

    $display("Sent %0d control steps over %0d register settings, checked %0d result words",
             queued, PHASES, words_checked);
    $display("Motor enable toggled %0d times, %0d course-out sequences entered",
             toggles, courseouts);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: line_follower_motor_fsm.f
rtl/lfm_pkg.sv
rtl/lfm_if.sv
rtl/lfm_scale.sv
rtl/lfm_button.sv
rtl/lfm_follow.sv
rtl/line_follower_motor_fsm.sv
tb/line_follower_motor_fsm_tb.sv
